// ----- sv/mfs_pkg.sv -----
// ----------------------------------------------------------------------------
// mfs_pkg: shared types and constants of the measurement frame serializer
// item kinds, register map, command format and the byte-wise crc-32 step
// ----------------------------------------------------------------------------
package mfs_pkg;

  localparam int unsigned ChannelsDef = 8;
  localparam int unsigned CntW        = 7;
  localparam logic [CntW-1:0] CountMax = '1;
  localparam int unsigned QueueDepth  = 2;
  localparam int unsigned DataW       = 96;
  localparam int unsigned AddrW       = 4;

  localparam logic [31:0] CrcInit = 32'hFFFF_FFFF;
  localparam logic [31:0] CrcPoly = 32'hEDB8_8320;

  // input item codes
  localparam logic [1:0] FuncHdr  = 2'd0;
  localparam logic [1:0] FuncChan = 2'd1;
  localparam logic [1:0] FuncTrl  = 2'd2;

  // register indexes
  localparam logic [1:0] RegMagic   = 2'd0;
  localparam logic [1:0] RegVersion = 2'd1;
  localparam logic [1:0] RegMsgType = 2'd2;

  typedef enum logic [1:0] {
    KIND_HDR,
    KIND_CHAN,
    KIND_TRL,
    KIND_ERR
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [DataW-1:0] data;
  } cmd_t;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  msg_type;
  } cfg_t;

  // reflected crc-32 over one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ----- sv/mfs_front.sv -----
// ----------------------------------------------------------------------------
// mfs_front: item classifier
// tracks frame state and channel count, turns each request into a command
// ----------------------------------------------------------------------------
module mfs_front #(
  parameter int unsigned CHANNELS = mfs_pkg::ChannelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 func_i,
  input  logic [31:0]                sequence_number_i,
  input  logic [63:0]                timestamp_us_i,
  input  logic signed [31:0]         channel_sample_i,
  input  logic [31:0]                status_word_i,
  output logic                       push_o,
  output mfs_pkg::cmd_t              cmd_o,
  input  logic                       full_i
);
  import mfs_pkg::*;

  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] count_q, count_d;
  logic            accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept;

  always_comb begin
    cmd_o.kind = KIND_ERR;
    cmd_o.data = '0;
    in_frame_d = in_frame_q;
    count_d    = count_q;
    unique case (func_i)
      FuncHdr: begin
        cmd_o.kind = KIND_HDR;
        cmd_o.data = {sequence_number_i, timestamp_us_i};
        in_frame_d = 1'b1;
        count_d    = '0;
      end
      FuncChan: begin
        if (in_frame_q) begin
          cmd_o.kind = KIND_CHAN;
          cmd_o.data = {64'h0, $unsigned(channel_sample_i)};
          if (count_q != CountMax) count_d = count_q + 1'b1;
        end else begin
          in_frame_d = 1'b0;
        end
      end
      FuncTrl: begin
        if (in_frame_q && count_q == CntW'(CHANNELS)) begin
          cmd_o.kind = KIND_TRL;
          cmd_o.data = {64'h0, status_word_i};
        end
        in_frame_d = 1'b0;
      end
      default: begin
        in_frame_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
    end else if (accept) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
    end
  end

endmodule

// ----- sv/mfs_queue.sv -----
// ----------------------------------------------------------------------------
// mfs_queue: short command queue
// decouples the classifier from the byte serializer
// ----------------------------------------------------------------------------
module mfs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mfs_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mfs_pkg::cmd_t cmd_o
);
  import mfs_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);

  cmd_t                 mem_q [QueueDepth];
  logic [PtrW-1:0]      wr_q, rd_q;
  logic [PtrW:0]        cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PtrW'(QueueDepth-1)) ? '0 : wr_q + 1'b1;
      if (do_pop)  rd_q <= (rd_q == PtrW'(QueueDepth-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
    end
  end

endmodule

// ----- sv/mfs_back.sv -----
// ----------------------------------------------------------------------------
// mfs_back: byte serializer
// walks each command byte by byte, folds the crc and feeds the output register
// ----------------------------------------------------------------------------
module mfs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  mfs_pkg::cfg_t cfg_i,
  input  logic          q_valid_i,
  input  mfs_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o,
  output logic          packet_end_o,
  output logic          frame_error_o
);
  import mfs_pkg::*;

  cmd_t        cmd_q;
  logic        busy_q;
  logic [3:0]  idx_q;
  logic [31:0] crc_q, crc_d;
  logic        ov_q, olast_q, oend_q, oerr_q;
  logic [7:0]  obyte_q;

  logic        load_ok, adv, last, fold;
  logic [3:0]  last_idx;
  logic [7:0]  cur_byte;
  logic [31:0] crc_base, crc_out;
  logic [127:0] hdr_vec;

  assign hdr_vec = {cfg_i.magic, cfg_i.version, cfg_i.msg_type, cmd_q.data};
  assign crc_out = ~crc_q;

  always_comb begin
    cur_byte = 8'h00;
    last_idx = 4'd0;
    fold     = 1'b0;
    unique case (cmd_q.kind)
      KIND_HDR: begin
        last_idx = 4'd15;
        cur_byte = 8'(hdr_vec >> {~idx_q, 3'b000});
        fold     = 1'b1;
      end
      KIND_CHAN: begin
        last_idx = 4'd3;
        cur_byte = 8'(cmd_q.data[31:0] >> {~idx_q[1:0], 3'b000});
        fold     = 1'b1;
      end
      KIND_TRL: begin
        last_idx = 4'd7;
        // status bytes first, then the inverted crc msb first
        cur_byte = idx_q[2] ? 8'(crc_out >> {~idx_q[1:0], 3'b000})
                            : 8'(cmd_q.data[31:0] >> {~idx_q[1:0], 3'b000});
        fold     = !idx_q[2];
      end
      default: begin
        last_idx = 4'd0;
      end
    endcase
  end

  assign load_ok = !ov_q || !out_stall_i;
  assign adv     = busy_q && load_ok;
  assign last    = (idx_q == last_idx);
  assign q_pop_o = q_valid_i && (!busy_q || (adv && last));

  // header restarts the crc on its first byte
  assign crc_base = (cmd_q.kind == KIND_HDR && idx_q == 4'd0) ? CrcInit : crc_q;

  always_comb begin
    crc_d = crc_q;
    if (adv) begin
      if (fold) crc_d = crc_byte(crc_base, cur_byte);
      if (last && (cmd_q.kind == KIND_TRL || cmd_q.kind == KIND_ERR)) crc_d = CrcInit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) cmd_q <= q_cmd_i;
    if (adv) begin
      obyte_q <= cur_byte;
      olast_q <= last;
      oend_q  <= last && (cmd_q.kind == KIND_TRL);
      oerr_q  <= (cmd_q.kind == KIND_ERR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      crc_q  <= CrcInit;
      ov_q   <= 1'b0;
    end else begin
      crc_q <= crc_d;
      if (q_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (adv) begin
        if (last) busy_q <= 1'b0;
        idx_q <= idx_q + 1'b1;
      end
      if (adv)           ov_q <= 1'b1;
      else if (load_ok)  ov_q <= 1'b0;
    end
  end

  assign out_valid_o   = ov_q;
  assign out_byte_o    = obyte_q;
  assign last_of_run_o = olast_q;
  assign packet_end_o  = oend_q;
  assign frame_error_o = oerr_q;

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oend_q |-> olast_q)
    else $error("packet end without end of run");

  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && oerr_q |-> olast_q && !oend_q && obyte_q == 8'h00)
    else $error("error result malformed");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= last_idx)
    else $error("byte index past end of command");

  a_crc_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last && cmd_q.kind == KIND_TRL |=> crc_q == CrcInit)
    else $error("crc not restarted after trailer");

endmodule

// ----- sv/measurement_frame_serializer_crc32_unit.sv -----
// ----------------------------------------------------------------------------
// measurement_frame_serializer_crc32_unit: framer with crc-32 trailer
// first byte: reaches the output register after the queue write, then the
//   serializer command load and the output register load
// throughput: one byte per cycle at the output register unless out_stall_i
//   holds it; a header is 16 bytes, a channel 4, a trailer 8, an error 1
// reset: queue empty, no frame open, crc all ones, config registers zero
// ----------------------------------------------------------------------------
module measurement_frame_serializer_crc32_unit #(
  parameter int unsigned CHANNELS = mfs_pkg::ChannelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // apb configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mfs_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // item input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 func_i,
  input  logic [31:0]                sequence_number_i,
  input  logic [63:0]                timestamp_us_i,
  input  logic signed [31:0]         channel_sample_i,
  input  logic [31:0]                status_word_i,
  // byte output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [7:0]                 out_byte_o,
  output logic                       last_of_run_o,
  output logic                       packet_end_o,
  output logic                       frame_error_o
);
  import mfs_pkg::*;

  cfg_t cfg_q;
  logic wr_en;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_full, q_valid, q_pop;

  // register writes complete on the access phase, no wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        RegMagic:   cfg_q.magic    <= pwdata[15:0];
        RegVersion: cfg_q.version  <= pwdata[7:0];
        RegMsgType: cfg_q.msg_type <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux, unused addresses read zero
  always_comb begin
    unique case (paddr[3:2])
      RegMagic:   prdata = {16'h0, cfg_q.magic};
      RegVersion: prdata = {24'h0, cfg_q.version};
      RegMsgType: prdata = {24'h0, cfg_q.msg_type};
      default:    prdata = 32'h0;
    endcase
  end

  // front: classify against frame state and channel count
  mfs_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .sequence_number_i (sequence_number_i),
    .timestamp_us_i    (timestamp_us_i),
    .channel_sample_i  (channel_sample_i),
    .status_word_i     (status_word_i),
    .push_o            (f_push),
    .cmd_o             (f_cmd),
    .full_i            (q_full)
  );

  // command queue between classifier and serializer
  mfs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .cmd_i   (f_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (q_cmd)
  );

  // back: one byte per cycle unless the output stalls, with running crc
  mfs_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_cmd_i       (q_cmd),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .packet_end_o  (packet_end_o),
    .frame_error_o (frame_error_o)
  );

endmodule
